// File: hdl/fss_pkg.sv
// Shared types, constants and helpers for the face spotlight shading pipeline.
// Used by fss_norm, face_spotlight_shading and the bench; depends on nothing else.
package fss_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    CFG_LIGHT_X  = 3'd0,
    CFG_LIGHT_Y  = 3'd1,
    CFG_LIGHT_Z  = 3'd2,
    CFG_CAMERA_X = 3'd3,
    CFG_CAMERA_Y = 3'd4,
    CFG_CAMERA_Z = 3'd5,
    CFG_RADIUS   = 3'd6
  } cfg_reg_e;

  // Normalizer structure: two root bits and two quotient bits per stage.
  localparam int SQ_ST    = 16;
  localparam int DV_ST    = 8;
  localparam int QBITS    = 15;
  localparam int NORM_LAT = 3 + SQ_ST + DV_ST + 1;

  localparam int HALF_Q14 = 8192;
  localparam int COEF_03  = 4915;

  typedef logic signed [34:0] wide_t;
  typedef logic signed [15:0] unit_t;

  // Drop 14 fraction bits, rounding to nearest with ties away from zero.
  function automatic logic signed [63:0] rnd14(input logic signed [63:0] x);
    logic [63:0] mg;
    mg = x[63] ? 64'(-x) : 64'(x);
    mg = (mg + 64'd8192) >> 14;
    return x[63] ? -$signed(mg) : $signed(mg);
  endfunction

endpackage

// File: hdl/fss_norm.sv
// Pipelined vector normalizer: scale, sum of squares, square root, divide.
// Turns a signed integer 3-vector into a Q2.14 unit vector. Uses fss_pkg.
module fss_norm import fss_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  wide_t vec_i  [3],
  output unit_t unit_o [3]
);

  typedef struct packed {
    logic [63:0]      x;
    logic [63:0]      r;
    logic [2:0]       sgn;
    logic [2:0][29:0] m;
  } sq_t;

  typedef struct packed {
    logic [2:0][31:0]      r;
    logic [2:0][QBITS-1:0] q;
    logic [31:0]           len;
    logic [2:0]            sgn;
  } dv_t;

  logic [29:0] m0_d [3];
  logic [29:0] m0_q [3];
  logic [2:0]  s0_d, s0_q;
  logic [59:0] sq1_q [3];
  logic [29:0] m1_q [3];
  logic [2:0]  s1_q;
  sq_t         sq_in_q;
  sq_t         sq_q [SQ_ST];
  dv_t         dv_q [DV_ST];
  unit_t       unit_q [3];

  // Bring the largest magnitude below 2^30 so the squares fit.
  always_comb begin
    logic [34:0] mg [3];
    logic [34:0] mx;
    logic [2:0]  sh;
    mx = '0;
    for (int j = 0; j < 3; j++) begin
      mg[j] = vec_i[j][34] ? 35'(-vec_i[j]) : 35'(vec_i[j]);
      if (mg[j] > mx) mx = mg[j];
    end
    priority if (mx[34]) sh = 3'd5;
    else if (mx[33]) sh = 3'd4;
    else if (mx[32]) sh = 3'd3;
    else if (mx[31]) sh = 3'd2;
    else if (mx[30]) sh = 3'd1;
    else             sh = 3'd0;
    for (int j = 0; j < 3; j++) begin
      m0_d[j] = 30'(mg[j] >> sh);
      s0_d[j] = vec_i[j][34];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m0_q <= m0_d;
      s0_q <= s0_d;
      for (int j = 0; j < 3; j++) begin
        sq1_q[j] <= 60'(m0_q[j]) * 60'(m0_q[j]);
      end
      m1_q <= m0_q;
      s1_q <= s0_q;
      sq_in_q.x   <= 64'(62'(sq1_q[0]) + 62'(sq1_q[1]) + 62'(sq1_q[2]));
      sq_in_q.r   <= '0;
      sq_in_q.sgn <= s1_q;
      for (int j = 0; j < 3; j++) begin
        sq_in_q.m[j] <= m1_q[j];
      end
    end
  end

  // Integer square root, digit by digit from the top.
  for (genvar g = 0; g < SQ_ST; g++) begin : g_sqrt
    sq_t cur, nxt;
    if (g == 0) begin : g_first
      assign cur = sq_in_q;
    end else begin : g_next
      assign cur = sq_q[g-1];
    end
    always_comb begin
      logic [63:0] x, r, b;
      nxt = cur;
      x = cur.x;
      r = cur.r;
      for (int t = 0; t < 2; t++) begin
        b = 64'd1 << (62 - 4 * g - 2 * t);
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
      end
      nxt.x = x;
      nxt.r = r;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) sq_q[g] <= nxt;
    end
  end

  // Restoring division of m * 2^14 by the length, one quotient bit a step.
  for (genvar g = 0; g < DV_ST; g++) begin : g_div
    dv_t cur, nxt;
    if (g == 0) begin : g_first
      always_comb begin
        cur.len = sq_q[SQ_ST-1].r[31:0];
        cur.sgn = sq_q[SQ_ST-1].sgn;
        cur.q   = '0;
        for (int j = 0; j < 3; j++) begin
          cur.r[j] = 32'(sq_q[SQ_ST-1].m[j]);
        end
      end
    end else begin : g_next
      assign cur = dv_q[g-1];
    end
    always_comb begin
      logic [31:0]      r;
      logic [QBITS-1:0] q;
      nxt = cur;
      for (int j = 0; j < 3; j++) begin
        r = cur.r[j];
        q = cur.q[j];
        for (int t = 0; t < 2; t++) begin
          if (2 * g + t < QBITS) begin
            if (2 * g + t > 0) r = r << 1;
            if (r >= cur.len) begin
              r = r - cur.len;
              q = {q[QBITS-2:0], 1'b1};
            end else begin
              q = {q[QBITS-2:0], 1'b0};
            end
          end
        end
        nxt.r[j] = r;
        nxt.q[j] = q;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) dv_q[g] <= nxt;
    end
  end

  // A zero-length vector comes out as the zero vector.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        if (dv_q[DV_ST-1].len == '0) begin
          unit_q[j] <= '0;
        end else if (dv_q[DV_ST-1].sgn[j]) begin
          unit_q[j] <= -16'(dv_q[DV_ST-1].q[j]);
        end else begin
          unit_q[j] <= 16'(dv_q[DV_ST-1].q[j]);
        end
      end
    end
  end

  assign unit_o = unit_q;

endmodule

// File: hdl/face_spotlight_shading.sv
// Top level of the per-face spotlight shading pipeline.
// Depends on fss_pkg and fss_norm.
//
//  channel | direction | signals                     | payload
//  --------+-----------+-----------------------------+------------------------------------
//  s_      | in        | s_tvalid/s_tready/s_tdata   | one triangle and object center
//  m_      | out       | m_tvalid/m_tready/m_tdata   | intensity, unsigned Q2.14
//  cfg_    | in        | cfg_valid/cfg_ready/index   | light, camera, radius limit
//
// One triangle enters per cycle unless the output register holds a transaction that is not taken.
// Most of the pipeline lies in the three parallel normalizers: a 16-stage square root
// and an 8-stage divider, two bits per stage.
// Reset clears the valid bits and the configuration registers to zero.
// When the output register holds a transaction that is not taken, the whole
// pipeline freezes together and nothing is lost or repeated.
module face_spotlight_shading import fss_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid,
  output logic         s_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, center_x, center_y
  input  logic [175:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // intensity
  output logic [15:0]  m_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [33:0]  cfg_data_i
);

  localparam int NVLD = 3 + NORM_LAT + 10;

  typedef struct packed {
    logic                   spot;
    logic [2:0][17:0]       sm;
    logic signed [15:0]     cx;
    logic signed [15:0]     cy;
  } side_t;

  // Configuration.
  logic signed [15:0] lgt_q [3];
  logic signed [15:0] cam_q [3];
  logic [33:0]        radius_limit_q;

  logic [NVLD-1:0] vld_q;
  logic            en;

  assign en          = !vld_q[NVLD-1] || m_tready;
  assign s_tready    = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q          <= '0;
      lgt_q          <= '{default: '0};
      cam_q          <= '{default: '0};
      radius_limit_q <= '0;
    end else begin
      if (en) vld_q <= {vld_q[NVLD-2:0], s_tvalid};
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_LIGHT_X:  lgt_q[0] <= cfg_data_i[15:0];
          CFG_LIGHT_Y:  lgt_q[1] <= cfg_data_i[15:0];
          CFG_LIGHT_Z:  lgt_q[2] <= cfg_data_i[15:0];
          CFG_CAMERA_X: cam_q[0] <= cfg_data_i[15:0];
          CFG_CAMERA_Y: cam_q[1] <= cfg_data_i[15:0];
          CFG_CAMERA_Z: cam_q[2] <= cfg_data_i[15:0];
          CFG_RADIUS:   radius_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Stage 1: edges, vertex sum, planar light distance squares.
  logic signed [15:0] fin [11];
  logic signed [16:0] e1_d [3], e2_d [3], e1_q [3], e2_q [3];
  logic signed [17:0] sm1_d [3], sm1_q [3];
  logic signed [15:0] cx1_q, cy1_q;
  logic signed [16:0] dx, dy;
  logic [33:0]        dx2_d, dy2_d, dx2_q, dy2_q;

  always_comb begin
    for (int k = 0; k < 11; k++) begin
      fin[k] = $signed(s_tdata[16*k +: 16]);
    end
    for (int j = 0; j < 3; j++) begin
      e1_d[j]  = 17'(fin[3+j]) - 17'(fin[j]);
      e2_d[j]  = 17'(fin[6+j]) - 17'(fin[3+j]);
      sm1_d[j] = 18'(fin[j]) + 18'(fin[3+j]) + 18'(fin[6+j]);
    end
    dx    = 17'(fin[9]) - 17'(lgt_q[0]);
    dy    = 17'(fin[10]) - 17'(lgt_q[1]);
    dx2_d = 34'(34'(dx) * 34'(dx));
    dy2_d = 34'(34'(dy) * 34'(dy));
  end

  // Stage 2: cross product terms, spot test, light and view directions.
  logic signed [33:0] pr_q [6];
  logic signed [18:0] ld2_q [3], id2_q [3];
  logic signed [17:0] sm2_q [3];
  logic signed [15:0] cx2_q, cy2_q;
  logic               spot2_q;

  // Stage 3: normalizer inputs.
  wide_t              cr_q [3];
  logic signed [18:0] ld3_q [3], id3_q [3];
  side_t              side3_q;
  wide_t              lvec [3], ivec [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lvec[j] = 35'(ld3_q[j]);
      ivec[j] = 35'(id3_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_q  <= e1_d;
      e2_q  <= e2_d;
      sm1_q <= sm1_d;
      cx1_q <= fin[9];
      cy1_q <= fin[10];
      dx2_q <= dx2_d;
      dy2_q <= dy2_d;

      pr_q[0] <= 34'(e1_q[1]) * 34'(e2_q[2]);
      pr_q[1] <= 34'(e1_q[2]) * 34'(e2_q[1]);
      pr_q[2] <= 34'(e1_q[2]) * 34'(e2_q[0]);
      pr_q[3] <= 34'(e1_q[0]) * 34'(e2_q[2]);
      pr_q[4] <= 34'(e1_q[0]) * 34'(e2_q[1]);
      pr_q[5] <= 34'(e1_q[1]) * 34'(e2_q[0]);
      for (int j = 0; j < 3; j++) begin
        ld2_q[j] <= 19'(lgt_q[j]) * 19'sd3 - 19'(sm1_q[j]);
        id2_q[j] <= 19'(cam_q[j]) * 19'sd3 - 19'(sm1_q[j]);
      end
      spot2_q <= (35'(dx2_q) + 35'(dy2_q)) < 35'(radius_limit_q);
      sm2_q   <= sm1_q;
      cx2_q   <= cx1_q;
      cy2_q   <= cy1_q;

      cr_q[0] <= 35'(pr_q[0]) - 35'(pr_q[1]);
      cr_q[1] <= 35'(pr_q[2]) - 35'(pr_q[3]);
      cr_q[2] <= 35'(pr_q[4]) - 35'(pr_q[5]);
      ld3_q   <= ld2_q;
      id3_q   <= id2_q;
      side3_q.spot <= spot2_q;
      for (int j = 0; j < 3; j++) begin
        side3_q.sm[j] <= sm2_q[j];
      end
      side3_q.cx <= cx2_q;
      side3_q.cy <= cy2_q;
    end
  end

  unit_t nu [3], lu [3], iu [3];

  fss_norm u_norm_n (.clk_i(clk_i), .en_i(en), .vec_i(cr_q), .unit_o(nu));
  fss_norm u_norm_l (.clk_i(clk_i), .en_i(en), .vec_i(lvec), .unit_o(lu));
  fss_norm u_norm_i (.clk_i(clk_i), .en_i(en), .vec_i(ivec), .unit_o(iu));

  // Side data waits alongside the normalizers.
  side_t side_q [NORM_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side3_q;
      for (int k = 1; k < NORM_LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Shading stages.
  logic signed [18:0] oa [3];
  logic signed [34:0] op_q [3];
  logic signed [31:0] lnp_q [3];
  unit_t              n1_q [3];
  unit_t              lc_q [3][3];
  unit_t              ic_q [4][3];
  logic [8:0]         spot_q;

  logic signed [33:0] dsum;
  logic signed [36:0] osum;
  logic signed [63:0] dr;
  logic [16:0]        diff_d;
  logic [16:0]        diff_q [7];
  unit_t              nf_d [3], nf_q [3];
  logic signed [33:0] pp_q [3];
  logic signed [19:0] rr_q [3];
  logic signed [35:0] qq_q [3];
  logic signed [37:0] qsum;
  logic signed [63:0] rr_r;
  logic [19:0]        ri_d, ri_q;
  logic [39:0]        ri2_q;
  logic [25:0]        s2;
  logic [51:0]        s4p_q;
  logic [37:0]        s4;
  logic [38:0]        dtot;
  logic               sat_d, sat_q;
  logic [30:0]        w_d, w_q;
  logic [16:0]        tot;
  logic [15:0]        out_d, out_q;

  always_comb begin
    oa[0] = 19'($signed(side_q[NORM_LAT-1].sm[0])) - 19'(side_q[NORM_LAT-1].cx) * 19'sd3;
    oa[1] = 19'($signed(side_q[NORM_LAT-1].sm[1])) - 19'(side_q[NORM_LAT-1].cy) * 19'sd3;
    oa[2] = 19'($signed(side_q[NORM_LAT-1].sm[2]));

    // The normal is flipped when it points toward the object center.
    dsum = 34'(lnp_q[0]) + 34'(lnp_q[1]) + 34'(lnp_q[2]);
    osum = 37'(op_q[0]) + 37'(op_q[1]) + 37'(op_q[2]);
    dr   = rnd14(osum[36] ? -64'(dsum) : 64'(dsum));
    diff_d = dr[63] ? '0 : 17'(dr);
    for (int j = 0; j < 3; j++) begin
      nf_d[j] = osum[36] ? -n1_q[j] : n1_q[j];
    end

    qsum = 38'(qq_q[0]) + 38'(qq_q[1]) + 38'(qq_q[2]);
    rr_r = rnd14(64'(qsum));
    ri_d = rr_r[63] ? '0 : 20'(rr_r);

    s2   = 26'((ri2_q + 40'd8192) >> 14);
    s4   = 38'((s4p_q + 52'd8192) >> 14);
    dtot = 39'(diff_q[6]) + 39'(s4);
    // Any sum from 2^18 up already drives the intensity into saturation.
    sat_d = |dtot[38:18];
    w_d   = 31'(dtot[17:0]) * 31'(COEF_03);

    tot = 17'(HALF_Q14) + 17'((w_q + 31'd8192) >> 14);
    if (!spot_q[8]) begin
      out_d = '0;
    end else if (sat_q || tot[16]) begin
      out_d = 16'hFFFF;
    end else begin
      out_d = 16'(tot);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      spot_q <= {spot_q[7:0], side_q[NORM_LAT-1].spot};
      for (int j = 0; j < 3; j++) begin
        op_q[j]  <= 35'(oa[j]) * 35'(nu[j]);
        lnp_q[j] <= 32'(lu[j]) * 32'(nu[j]);
      end
      n1_q     <= nu;
      lc_q[0]  <= lu;
      lc_q[1]  <= lc_q[0];
      lc_q[2]  <= lc_q[1];
      ic_q[0]  <= iu;
      ic_q[1]  <= ic_q[0];
      ic_q[2]  <= ic_q[1];
      ic_q[3]  <= ic_q[2];

      diff_q[0] <= diff_d;
      for (int k = 1; k < 7; k++) begin
        diff_q[k] <= diff_q[k-1];
      end
      nf_q <= nf_d;

      for (int j = 0; j < 3; j++) begin
        pp_q[j] <= 34'($signed({1'b0, diff_q[0]})) * 34'(nf_q[j]);
        rr_q[j] <= 20'(rnd14(64'(pp_q[j]) * 64'sd2)) - 20'(lc_q[2][j]);
        qq_q[j] <= 36'(rr_q[j]) * 36'(ic_q[3][j]);
      end

      ri_q  <= ri_d;
      ri2_q <= 40'(ri_q) * 40'(ri_q);
      s4p_q <= 52'(s2) * 52'(s2);
      sat_q <= sat_d;
      w_q   <= w_d;
      out_q <= out_d;
    end
  end

  assign m_tvalid = vld_q[NVLD-1];
  assign m_tdata  = out_q;

endmodule

// File: sim/face_spotlight_shading_tb.sv
// Self-checking bench for face_spotlight_shading: directed triangles, then random
// ones, compared with a behavioral shading predictor. Depends on fss_pkg and the RTL.
module face_spotlight_shading_tb import fss_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk_i;
  logic         rst_ni;
  logic         s_tvalid;
  logic         s_tready;
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, center_x, center_y
  logic [175:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  // intensity
  logic [15:0]  m_tdata;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [33:0]  cfg_data_i;

  face_spotlight_shading i_dut (.*);

  typedef struct {
    logic [15:0] intensity;
    bit          known;
  } shade_t;

  longint light_q[3], camera_q[3];
  longint radius_q;
  shade_t expected_shades[$];
  int     error_count;
  int     hold_off;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint round14(longint x);
    longint r;
    r = (mag(x) + HALF_Q14) >>> 14;
    return x < 0 ? -r : r;
  endfunction

  function automatic longint int_sqrt(longint x);
    longint res, b;
    res = 0;
    b = 64'sd1 << 62;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - res - b;
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  // Unit vector in Q2.14, after shrinking magnitudes below 2^30.
  function automatic void to_unit(input longint c[3], output longint n[3]);
    longint m[3], mx, acc, len, q;
    int sh;
    mx = 0; acc = 0; sh = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(c[i]);
      if (m[i] > mx) mx = m[i];
    end
    while ((mx >>> sh) >= (64'sd1 << 30)) sh++;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >>> sh;
      acc += m[i] * m[i];
    end
    len = int_sqrt(acc);
    for (int i = 0; i < 3; i++) begin
      q = (len == 0) ? 0 : (m[i] * 16384) / len;
      n[i] = c[i] < 0 ? -q : q;
    end
  endfunction

  function automatic logic [15:0] predict_shade(logic [175:0] tri_bits);
    longint v[3][3], e1[3], e2[3], cr[3], nn[3], vsum[3];
    longint ld[3], id[3], lu[3], iu[3], rr[3];
    longint cx, cy, dx, dy, dist_sq, diff, ri, s2, s4, tot;
    for (int i = 0; i < 9; i++) v[i/3][i%3] = longint'($signed(tri_bits[16*i +: 16]));
    cx = longint'($signed(tri_bits[144 +: 16]));
    cy = longint'($signed(tri_bits[160 +: 16]));
    dx = cx - light_q[0];
    dy = cy - light_q[1];
    dist_sq = dx * dx + dy * dy;
    if (!(dist_sq < radius_q)) return 16'd0;
    for (int j = 0; j < 3; j++) begin
      e1[j] = v[1][j] - v[0][j];
      e2[j] = v[2][j] - v[1][j];
      vsum[j] = v[0][j] + v[1][j] + v[2][j];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    to_unit(cr, nn);
    if ((vsum[0] - 3 * cx) * nn[0] + (vsum[1] - 3 * cy) * nn[1] + vsum[2] * nn[2] < 0)
      for (int j = 0; j < 3; j++) nn[j] = -nn[j];
    for (int j = 0; j < 3; j++) begin
      ld[j] = 3 * light_q[j] - vsum[j];
      id[j] = 3 * camera_q[j] - vsum[j];
    end
    to_unit(ld, lu);
    to_unit(id, iu);
    diff = round14(lu[0] * nn[0] + lu[1] * nn[1] + lu[2] * nn[2]);
    if (diff < 0) diff = 0;
    for (int j = 0; j < 3; j++) rr[j] = round14(2 * diff * nn[j]) - lu[j];
    ri = round14(rr[0] * iu[0] + rr[1] * iu[1] + rr[2] * iu[2]);
    if (ri < 0) ri = 0;
    s2 = round14(ri * ri);
    s4 = round14(s2 * s2);
    tot = HALF_Q14 + round14((diff + s4) * COEF_03);
    if (tot > 65535) tot = 65535;
    return 16'(tot);
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Leaves cfg_valid_i high; set_scene drops it after the last write.
  task automatic write_reg(cfg_reg_e idx, logic [33:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_LIGHT_X:  light_q[0]  = longint'($signed(val[15:0]));
      CFG_LIGHT_Y:  light_q[1]  = longint'($signed(val[15:0]));
      CFG_LIGHT_Z:  light_q[2]  = longint'($signed(val[15:0]));
      CFG_CAMERA_X: camera_q[0] = longint'($signed(val[15:0]));
      CFG_CAMERA_Y: camera_q[1] = longint'($signed(val[15:0]));
      CFG_CAMERA_Z: camera_q[2] = longint'($signed(val[15:0]));
      CFG_RADIUS:   radius_q    = longint'(val);
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_scene(logic [15:0] lx, logic [15:0] ly, logic [15:0] lz,
                           logic [15:0] kx, logic [15:0] ky, logic [15:0] kz,
                           logic [33:0] rad);
    write_reg(CFG_LIGHT_X, {18'd0, lx});
    write_reg(CFG_LIGHT_Y, {18'd0, ly});
    write_reg(CFG_LIGHT_Z, {18'd0, lz});
    write_reg(CFG_CAMERA_X, {18'd0, kx});
    write_reg(CFG_CAMERA_Y, {18'd0, ky});
    write_reg(CFG_CAMERA_Z, {18'd0, kz});
    write_reg(CFG_RADIUS, rad);
    cfg_valid_i <= 1'b0;
  endtask

  // One triangle transaction; known marks a typed-in expectation.
  // s_tvalid stays high after the transaction until the next idle gap or drain.
  task automatic send_triangle(logic [175:0] tri_bits, bit known, logic [15:0] want);
    shade_t e;
    int     idle;
    idle = $urandom_range(0, 9);
    if (idle > 0) begin
      s_tvalid <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= tri_bits;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    e.intensity = known ? want : predict_shade(tri_bits);
    e.known = known;
    expected_shades.push_back(e);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_shades.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  function automatic logic [175:0] random_triangle(bit nearby);
    logic [175:0] t;
    for (int i = 0; i < 11; i++)
      t[16*i +: 16] = nearby ? 16'($urandom_range(0, 2047) - 1024) : 16'($urandom);
    return t;
  endfunction

  // Receiver: a random wait before each transaction plus one long hold-off.
  initial begin
    shade_t e;
    int     wait_cycles;
    m_tready = 1'b0;
    wait_cycles = $urandom_range(0, 9);
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        m_tready <= 1'b0;
        hold_off--;
      end else if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        wait_cycles--;
      end else begin
        m_tready <= 1'b1;
      end
      @(posedge clk_i);
      if (m_tvalid && m_tready) begin
        wait_cycles = $urandom_range(0, 9);
        if (expected_shades.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = expected_shades.pop_front();
          if (m_tdata !== e.intensity)
            report_mismatch($sformatf("intensity %0d, expected %0d%s", m_tdata,
                                      e.intensity, e.known ? " (table)" : ""));
        end
      end
    end
  end

  typedef struct {
    logic [175:0] tri_bits;
    bit           known;
    logic [15:0]  want;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    logic [175:0] t;
    error_count = 0;
    hold_off = 0;
    rst_ni = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_LIGHT_X;
    cfg_data_i = '0;
    foreach (light_q[i]) begin
      light_q[i] = 0;
      camera_q[i] = 0;
    end
    radius_q = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // After reset the radius is zero, so every triangle is outside the spot.
    rows.push_back('{'1, 1, 16'd0});
    rows.push_back('{'0, 1, 16'd0});
    foreach (rows[i]) send_triangle(rows[i].tri_bits, rows[i].known, rows[i].want);
    drain();
    rows.delete();

    set_scene(16'h0000, 16'h0000, 16'h0400, 16'h0000, 16'h0000, 16'h0400, 34'h3FFFFFFFF);
    // Degenerate triangle: zero normal gives only the ambient term.
    rows.push_back('{{16'd0, 16'd0, {9{16'h0100}}}, 1, 16'd8192});
    // All-zero triangle at the light's foot.
    rows.push_back('{'0, 0, 16'd0});
    // Flat triangle in z=0 facing the light and the camera, and its reverse winding.
    rows.push_back('{{16'd0, 16'd0, 16'd0, 16'h0100, 16'h0000, 16'd0, 16'h0000,
                      16'h0100, 16'd0, 16'h0000, 16'h0000}, 0, 16'd0});
    rows.push_back('{{16'd0, 16'd0, 16'd0, 16'h0000, 16'h0100, 16'd0, 16'h0100,
                      16'h0000, 16'd0, 16'h0000, 16'h0000}, 0, 16'd0});
    // Extreme coordinates.
    rows.push_back('{{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                      16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 0, 16'd0});
    rows.push_back('{{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                      16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 0, 16'd0});
    for (int i = 0; i < 8; i++) rows.push_back('{random_triangle(1), 0, 16'd0});
    foreach (rows[i]) send_triangle(rows[i].tri_bits, rows[i].known, rows[i].want);
    drain();

    // Extreme light, radius exactly at a center's distance: not strictly below.
    set_scene(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 34'h1_0000);
    send_triangle({16'h7FFF, 16'h8100, {9{16'h1234}}}, 1, 16'd0);
    send_triangle({16'h7FFF, 16'h8001, {9{16'h0100}}}, 0, 16'd0);
    drain();

    // Random scenes; one phase has a long output hold-off.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 3 == 0)
        set_scene(16'($urandom_range(0, 2047) - 1024), 16'($urandom_range(0, 2047) - 1024),
                  16'($urandom_range(0, 4095) - 2048), 16'($urandom), 16'($urandom),
                  16'($urandom), 34'($urandom_range(0, 1 << 30)) << 3);
      else
        set_scene(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom),
                  (ph == 1) ? 34'd0 : {2'($urandom), 32'($urandom)});
      if (ph == 4) hold_off = 300;
      for (int k = 0; k < 155; k++) begin
        t = random_triangle($urandom_range(0, 3) != 0);
        if (ph % 3 == 0)
          t[144 +: 32] = {16'(light_q[1] + $urandom_range(0, 64) - 32),
                          16'(light_q[0] + $urandom_range(0, 64) - 32)};
        send_triangle(t, 0, 16'd0);
      end
      drain();
    end

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
